// File: rtl/tvfl_pkg.sv
// Shared types and constants of the trilinear vector field lookup.
package tvfl_pkg;

    localparam int LOAD_ADDR_W = 15;
    localparam int IDX_W       = 8;
    localparam int FRAC_W      = 17;
    localparam int LIN_W       = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_ORIGIN_Z   = 3'd2,
        CFG_INV_STEP_X = 3'd3,
        CFG_INV_STEP_Y = 3'd4,
        CFG_INV_STEP_Z = 3'd5,
        CFG_SCALE      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] bz;
        logic signed [31:0] by;
        logic signed [31:0] bx;
    } t_vec;

    typedef struct packed {
        logic                   func;
        logic signed [31:0]     pos_x;
        logic signed [31:0]     pos_y;
        logic signed [31:0]     pos_z;
        logic [LOAD_ADDR_W-1:0] load_addr;
        logic signed [31:0]     load_bx;
        logic signed [31:0]     load_by;
        logic signed [31:0]     load_bz;
    } t_in;

    typedef struct packed {
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
        logic               inside_res;
    } t_out;

endpackage

// File: rtl/trilinear_vector_field_lookup.sv
// Trilinear vector field lookup: top level with config, pipeline control and scaling.
//
// Input channel i_in_valid/o_in_ready carries t_in transactions. func = 0 writes
// one Q8.24 sample triple at load_addr and gives no result; func = 1 queries a
// Q16.16 position and gives one t_out transaction on o_out_valid/i_out_ready.
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
// Throughput: one transaction per cycle while i_out_ready is high; the eight cell
// corners come from eight replicated copies of the grid store, each read once per cycle.
// Every stage has its own valid bit and moves when it is empty or the stage
// after it moves, so a stalled receiver fills the bubbles first and then holds
// o_in_ready low; nothing is dropped or repeated.
// Reset clears all valid bits and loads origin 0, step 1.0 and scale 1.0. The
// grid store is not cleared; its entries are undefined until loaded.
// Load addresses at or beyond GRID_X*GRID_Y*GRID_Z are ignored.
module trilinear_vector_field_lookup #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  tvfl_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output tvfl_pkg::t_out                    o_out_data,
    input  logic                              i_cfg_we,
    input  logic [tvfl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tvfl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CELLS     = GRID_X * GRID_Y * GRID_Z;
    localparam int SPAN      = 2 ** tvfl_pkg::LOAD_ADDR_W;
    localparam int MEM_DEPTH = (CELLS > SPAN) ? SPAN : CELLS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int NS        = 13;

    localparam int IW = tvfl_pkg::IDX_W;
    localparam int FW = tvfl_pkg::FRAC_W;
    localparam int LW = tvfl_pkg::LIN_W;

    // configuration
    logic signed [31:0] r_org_x, r_org_y, r_org_z, r_scale;
    logic [30:0]        r_inv_x, r_inv_y, r_inv_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_inv_x <= 31'd65536;
            r_inv_y <= 31'd65536;
            r_inv_z <= 31'd65536;
            r_scale <= 32'sd65536;
        end else if (i_cfg_we) begin
            case (tvfl_pkg::t_cfg_idx'(i_cfg_idx))
                tvfl_pkg::CFG_ORIGIN_X:   r_org_x <= i_cfg_data;
                tvfl_pkg::CFG_ORIGIN_Y:   r_org_y <= i_cfg_data;
                tvfl_pkg::CFG_ORIGIN_Z:   r_org_z <= i_cfg_data;
                tvfl_pkg::CFG_INV_STEP_X: r_inv_x <= i_cfg_data[30:0];
                tvfl_pkg::CFG_INV_STEP_Y: r_inv_y <= i_cfg_data[30:0];
                tvfl_pkg::CFG_INV_STEP_Z: r_inv_z <= i_cfg_data[30:0];
                tvfl_pkg::CFG_SCALE:      r_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic [NS+1:1] en;
    logic [NS:1]   r_v;

    always_comb begin
        en[NS+1] = i_out_ready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_in_ready = en[1];

    // load transactions drop out after the store stage
    logic               r_func  [1:4];
    logic [tvfl_pkg::LOAD_ADDR_W-1:0] r_laddr [1:4];
    tvfl_pkg::t_vec     r_ldata [1:4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_in_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 5) ? (r_v[4] && r_func[4] == tvfl_pkg::FUNC_QUERY)
                                       : r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_func[1]     <= i_in_data.func;
            r_laddr[1]    <= i_in_data.load_addr;
            r_ldata[1].bx <= i_in_data.load_bx;
            r_ldata[1].by <= i_in_data.load_by;
            r_ldata[1].bz <= i_in_data.load_bz;
        end
        for (int k = 2; k <= 4; k++) begin
            if (en[k]) begin
                r_func[k]  <= r_func[k-1];
                r_laddr[k] <= r_laddr[k-1];
                r_ldata[k] <= r_ldata[k-1];
            end
        end
    end

    // stages 1..3: coordinate mapping
    logic [IW-1:0] idx_x, idx_y, idx_z;
    logic [FW-1:0] frac_x, frac_y, frac_z;
    logic          ins_x, ins_y, ins_z;

    tvfl_axis_map #(.N(GRID_X)) u_map_x (
        .i_clk(i_clk), .i_en(en[3:1]), .i_pos(i_in_data.pos_x), .i_org(r_org_x),
        .i_inv(r_inv_x), .o_idx(idx_x), .o_frac(frac_x), .o_inside(ins_x)
    );
    tvfl_axis_map #(.N(GRID_Y)) u_map_y (
        .i_clk(i_clk), .i_en(en[3:1]), .i_pos(i_in_data.pos_y), .i_org(r_org_y),
        .i_inv(r_inv_y), .o_idx(idx_y), .o_frac(frac_y), .o_inside(ins_y)
    );
    tvfl_axis_map #(.N(GRID_Z)) u_map_z (
        .i_clk(i_clk), .i_en(en[3:1]), .i_pos(i_in_data.pos_z), .i_org(r_org_z),
        .i_inv(r_inv_z), .o_idx(idx_z), .o_frac(frac_z), .o_inside(ins_z)
    );

    // fractions and inside flag follow the data
    logic [FW-1:0] r_fx [4:9];
    logic [FW-1:0] r_fy [4:7];
    logic [FW-1:0] r_fz [4:5];
    logic          r_ins [4:12];

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_fx[4]  <= frac_x;
            r_fy[4]  <= frac_y;
            r_fz[4]  <= frac_z;
            r_ins[4] <= ins_x && ins_y && ins_z;
        end
        for (int k = 5; k <= 12; k++) begin
            if (en[k]) begin
                r_ins[k] <= r_ins[k-1];
                if (k <= 9) r_fx[k] <= r_fx[k-1];
                if (k <= 7) r_fy[k] <= r_fy[k-1];
                if (k <= 5) r_fz[k] <= r_fz[k-1];
            end
        end
    end

    // stage 4: corner addresses, stage 5: corner reads
    logic [ADDR_W-1:0] r_raddr [8];
    tvfl_pkg::t_vec    rd [8];
    logic              we;

    assign we = en[5] && r_v[4] && r_func[4] == tvfl_pkg::FUNC_LOAD
             && 32'(r_laddr[4]) < CELLS;

    for (genvar c = 0; c < 8; c++) begin : g_corner
        localparam logic [LW-1:0] DX = LW'((c / 4) % 2);
        localparam logic [LW-1:0] DY = LW'((c / 2) % 2);
        localparam logic [LW-1:0] DZ = LW'(c % 2);
        logic [LW-1:0] row;
        logic [LW-1:0] lin;

        assign row = LW'((LW'(idx_x) + DX) * LW'(GRID_Y)) + LW'(idx_y) + DY;
        assign lin = LW'(row * LW'(GRID_Z)) + LW'(idx_z) + DZ;

        always_ff @(posedge i_clk) begin
            if (en[4]) begin
                r_raddr[c] <= lin[ADDR_W-1:0];
            end
        end

        tvfl_grid_ram #(.DEPTH(MEM_DEPTH), .ADDR_W(ADDR_W)) u_ram (
            .i_clk(i_clk), .i_we(we), .i_waddr(r_laddr[4][ADDR_W-1:0]),
            .i_wdata(r_ldata[4]), .i_re(en[5]), .i_raddr(r_raddr[c]),
            .o_rdata(rd[c])
        );
    end

    function automatic logic signed [31:0] comp(input tvfl_pkg::t_vec v, input int k);
        case (k)
            0:       comp = v.bx;
            1:       comp = v.by;
            default: comp = v.bz;
        endcase
    endfunction

    // stages 6..11: interpolation along z, then y, then x
    logic signed [31:0] zr [3][4];
    logic signed [31:0] yr [3][2];
    logic signed [31:0] xr [3];

    for (genvar k = 0; k < 3; k++) begin : g_comp
        for (genvar p = 0; p < 4; p++) begin : g_z
            tvfl_lerp u_lerp (
                .i_clk(i_clk), .i_en(en[7:6]), .i_a(comp(rd[2*p], k)),
                .i_b(comp(rd[2*p+1], k)), .i_f(r_fz[5]), .o_r(zr[k][p])
            );
        end
        for (genvar q = 0; q < 2; q++) begin : g_y
            tvfl_lerp u_lerp (
                .i_clk(i_clk), .i_en(en[9:8]), .i_a(zr[k][2*q]),
                .i_b(zr[k][2*q+1]), .i_f(r_fy[7]), .o_r(yr[k][q])
            );
        end
        tvfl_lerp u_lerp_x (
            .i_clk(i_clk), .i_en(en[11:10]), .i_a(yr[k][0]),
            .i_b(yr[k][1]), .i_f(r_fx[9]), .o_r(xr[k])
        );
    end

    // stage 12: scale, stage 13: floor, saturate, output register
    logic signed [63:0] r_sp [3];
    logic signed [31:0] sat  [3];
    tvfl_pkg::t_out     r_out;
    tvfl_pkg::t_out     n_out;

    always_ff @(posedge i_clk) begin
        if (en[12]) begin
            for (int k = 0; k < 3; k++) begin
                r_sp[k] <= xr[k] * r_scale;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            // fits when bits 63..47 all agree
            if (r_sp[k][63:47] == {17{r_sp[k][63]}}) begin
                sat[k] = $signed(r_sp[k][47:16]);
            end else if (r_sp[k][63]) begin
                sat[k] = 32'sh8000_0000;
            end else begin
                sat[k] = 32'sh7FFF_FFFF;
            end
        end
        n_out.inside_res = r_ins[12];
        n_out.field_x    = r_ins[12] ? sat[0] : '0;
        n_out.field_y    = r_ins[12] ? sat[1] : '0;
        n_out.field_z    = r_ins[12] ? sat[2] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (en[13]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v[NS];
    assign o_out_data  = r_out;

endmodule

// File: rtl/tvfl_axis_map.sv
// Three-stage mapping of one position coordinate to cell index and fraction.
module tvfl_axis_map #(
    parameter int N = 32
) (
    input  logic                         i_clk,
    input  logic [2:0]                   i_en,
    input  logic signed [31:0]           i_pos,
    input  logic signed [31:0]           i_org,
    input  logic [30:0]                  i_inv,
    output logic [tvfl_pkg::IDX_W-1:0]   o_idx,
    output logic [tvfl_pkg::FRAC_W-1:0]  o_frac,
    output logic                         o_inside
);

    localparam logic [46:0] LIM  = 47'(N - 1) << 16;
    localparam logic [30:0] LAST = 31'(N - 1);

    logic [32:0] r_rel;
    logic [62:0] r_prod;
    logic        r_neg;
    logic [tvfl_pkg::IDX_W-1:0]  r_idx;
    logic [tvfl_pkg::FRAC_W-1:0] r_frac;
    logic        r_inside;

    logic [46:0] coord;
    logic [tvfl_pkg::IDX_W-1:0]  n_idx;
    logic [tvfl_pkg::FRAC_W-1:0] n_frac;
    logic        n_inside;

    always_comb begin
        coord    = r_prod[62:16];
        n_inside = !r_neg && (coord <= LIM);
        // upper face: stay in the last cell with a full fraction
        if (coord[46:16] >= LAST) begin
            n_idx  = tvfl_pkg::IDX_W'(N - 2);
            n_frac = tvfl_pkg::FRAC_ONE;
        end else begin
            n_idx  = coord[tvfl_pkg::IDX_W+15:16];
            n_frac = {1'b0, coord[15:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rel <= {i_pos[31], i_pos} - {i_org[31], i_org};
        end
        if (i_en[1]) begin
            r_prod <= 63'(r_rel[31:0]) * 63'(i_inv);
            r_neg  <= r_rel[32];
        end
        if (i_en[2]) begin
            r_idx    <= n_idx;
            r_frac   <= n_frac;
            r_inside <= n_inside;
        end
    end

    assign o_idx    = r_idx;
    assign o_frac   = r_frac;
    assign o_inside = r_inside;

endmodule

// File: rtl/tvfl_grid_ram.sv
// One copy of the grid sample store: one write port, one registered read port.
module tvfl_grid_ram #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  tvfl_pkg::t_vec    i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output tvfl_pkg::t_vec    o_rdata
);

    tvfl_pkg::t_vec r_mem [DEPTH];
    tvfl_pkg::t_vec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tvfl_lerp.sv
// Two-stage linear step a + floor((b - a) * f / 65536).
module tvfl_lerp (
    input  logic                         i_clk,
    input  logic [1:0]                   i_en,
    input  logic signed [31:0]           i_a,
    input  logic signed [31:0]           i_b,
    input  logic [tvfl_pkg::FRAC_W-1:0]  i_f,
    output logic signed [31:0]           o_r
);

    logic signed [32:0] diff;
    logic signed [17:0] fs;
    logic signed [50:0] r_p;
    logic signed [31:0] r_a;
    logic signed [31:0] r_r;

    assign diff = 33'(i_b) - 33'(i_a);
    assign fs   = {1'b0, i_f};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p <= diff * fs;
            r_a <= i_a;
        end
        // result lies between a and b, so 32 bits hold it
        if (i_en[1]) begin
            r_r <= r_a + $signed(r_p[47:16]);
        end
    end

    assign o_r = r_r;

endmodule

// File: verif/tb_top.sv
// Testbench for trilinear_vector_field_lookup: directed table, random traffic, scoreboard.
module tb_top;

    localparam int GX = 32;
    localparam int GY = 32;
    localparam int GZ = 32;
    localparam int CELLS = GX * GY * GZ;
    localparam int DRAIN_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 3000000;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    tvfl_pkg::t_in                   i_in_data = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    tvfl_pkg::t_out                  o_out_data;
    logic                            i_cfg_we = 1'b0;
    logic [tvfl_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [tvfl_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    trilinear_vector_field_lookup #(.GRID_X(GX), .GRID_Y(GY), .GRID_Z(GZ)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // shadow of the grid and the registers
    int              grid_mem [CELLS][3];
    longint          sh_origin [3];
    longint unsigned sh_inv_step [3];
    longint          sh_scale;

    tvfl_pkg::t_out expected_fields [$];
    int     n_fail = 0;
    longint cycle_count = 0;
    bit     rx_no_stall = 1'b0;
    bit     tx_no_gap = 1'b0;

    typedef struct {
        tvfl_pkg::t_in  item;
        bit             typed;
        tvfl_pkg::t_out want;
    } t_row;

    t_row directed_rows [$];

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
            if (i_clk) begin
                cycle_count++;
                if (cycle_count > CYCLE_LIMIT) begin
                    $display("timeout at %0t", $time);
                    $display("tb_top NOT OK");
                    $finish;
                end
            end
        end
    end

    function automatic bit map_cell(input logic signed [31:0] p, input longint org,
                                    input longint unsigned inv, input int n,
                                    output int idx, output longint fr);
        longint rel;
        longint unsigned c;
        idx = 0;
        fr = 0;
        rel = longint'(p) - org;
        if (rel < 0) return 1'b0;
        c = (unsigned'(rel) * inv) >> 16;
        if (c > (64'(n - 1) << 16)) return 1'b0;
        idx = int'(c >> 16);
        fr = longint'(c & 64'hFFFF);
        if (idx >= n - 1) begin
            idx = n - 2;
            fr = 65536;
        end
        return 1'b1;
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint f);
        return a + (((b - a) * f) >>> 16);
    endfunction

    function automatic longint corner(input int ix, input int iy, input int iz, input int k);
        return longint'(grid_mem[(ix * GY + iy) * GZ + iz][k]);
    endfunction

    function automatic tvfl_pkg::t_out interpolate_field(input tvfl_pkg::t_in d);
        tvfl_pkg::t_out r;
        int     ix, iy, iz;
        longint fx, fy, fz, z00, z01, z10, z11, y0, y1, v, s;
        bit     ins;
        r = '0;
        ins = map_cell(d.pos_x, sh_origin[0], sh_inv_step[0], GX, ix, fx);
        if (ins) ins = map_cell(d.pos_y, sh_origin[1], sh_inv_step[1], GY, iy, fy);
        if (ins) ins = map_cell(d.pos_z, sh_origin[2], sh_inv_step[2], GZ, iz, fz);
        r.inside_res = ins;
        if (!ins) return r;
        for (int k = 0; k < 3; k++) begin
            z00 = blend(corner(ix, iy, iz, k), corner(ix, iy, iz + 1, k), fz);
            z01 = blend(corner(ix, iy + 1, iz, k), corner(ix, iy + 1, iz + 1, k), fz);
            z10 = blend(corner(ix + 1, iy, iz, k), corner(ix + 1, iy, iz + 1, k), fz);
            z11 = blend(corner(ix + 1, iy + 1, iz, k),
                        corner(ix + 1, iy + 1, iz + 1, k), fz);
            y0 = blend(z00, z01, fy);
            y1 = blend(z10, z11, fy);
            v = blend(y0, y1, fx);
            s = (v * sh_scale) >>> 16;
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            if (k == 0) r.field_x = s[31:0];
            else if (k == 1) r.field_y = s[31:0];
            else r.field_z = s[31:0];
        end
        return r;
    endfunction

    // model side effect of one accepted transaction
    function automatic void accept_item(input tvfl_pkg::t_in d, input bit typed,
                                        input tvfl_pkg::t_out want);
        if (d.func == tvfl_pkg::FUNC_LOAD) begin
            if (int'(d.load_addr) < CELLS) begin
                grid_mem[d.load_addr][0] = d.load_bx;
                grid_mem[d.load_addr][1] = d.load_by;
                grid_mem[d.load_addr][2] = d.load_bz;
            end
        end else begin
            expected_fields.push_back(typed ? want : interpolate_field(d));
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_no_gap) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input tvfl_pkg::t_in d, input bit typed,
                             input tvfl_pkg::t_out want);
        int g;
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= d;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        accept_item(d, typed, want);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [31:0] vals [7]);
        for (int i = 0; i < 7; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= tvfl_pkg::CFG_IDX_W'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        for (int a = 0; a < 3; a++) begin
            sh_origin[a] = longint'(signed'(vals[tvfl_pkg::CFG_ORIGIN_X + a]));
            sh_inv_step[a] = longint'(vals[tvfl_pkg::CFG_INV_STEP_X + a] & 32'h7FFF_FFFF);
        end
        sh_scale = longint'(signed'(vals[tvfl_pkg::CFG_SCALE]));
    endtask

    function automatic tvfl_pkg::t_in mk(input logic f, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z,
                                         input int addr, input logic [31:0] bx,
                                         input logic [31:0] by, input logic [31:0] bz);
        tvfl_pkg::t_in d;
        d.func = f;
        d.pos_x = x;
        d.pos_y = y;
        d.pos_z = z;
        d.load_addr = tvfl_pkg::LOAD_ADDR_W'(addr);
        d.load_bx = bx;
        d.load_by = by;
        d.load_bz = bz;
        return d;
    endfunction

    task automatic add_row(input tvfl_pkg::t_in d, input bit typed);
        t_row r;
        r.item = d;
        r.typed = typed;
        r.want = '0;
        directed_rows.push_back(r);
    endtask

    // per axis only the first four and the last two indexes get loaded
    function automatic bit is_loaded_idx(input int i, input int n);
        return (i <= 3) || (i >= n - 2);
    endfunction

    // positions that touch only loaded corners: low cells, the far cell, or outside
    function automatic logic [31:0] pick_pos(input int a);
        longint t, rel, v, fr;
        int     idx, n, r;
        n = (a == 0) ? GX : (a == 1) ? GY : GZ;
        for (int tries = 0; tries < 8; tries++) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                v = longint'(signed'($urandom));
            end else begin
                if (r < 6) t = $urandom_range(0, (3 << 16) - 1);
                else if (r < 9) t = $urandom_range((n - 2) << 16, (n - 1) << 16);
                else t = $urandom_range(((n - 1) << 16) + 1, (n + 8) << 16);
                if (sh_inv_step[a] == 0) rel = $urandom_range(0, 1 << 20);
                else rel = (t << 16) / longint'(sh_inv_step[a]);
                v = sh_origin[a] + rel;
                if (v > 64'sd2147483647) v = 64'sd2147483647;
            end
            if (!map_cell(v[31:0], sh_origin[a], sh_inv_step[a], n, idx, fr)
                || idx <= 2 || idx == n - 2)
                return v[31:0];
        end
        return sh_origin[a][31:0];
    endfunction

    function automatic tvfl_pkg::t_in random_item();
        tvfl_pkg::t_in d;
        d.pos_x = $urandom;
        d.pos_y = $urandom;
        d.pos_z = $urandom;
        d.load_addr = tvfl_pkg::LOAD_ADDR_W'($urandom);
        d.load_bx = $urandom;
        d.load_by = $urandom;
        d.load_bz = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            d.func = tvfl_pkg::FUNC_LOAD;
        end else begin
            d.func = tvfl_pkg::FUNC_QUERY;
            d.pos_x = pick_pos(0);
            d.pos_y = pick_pos(1);
            d.pos_z = pick_pos(2);
        end
        return d;
    endfunction

    // result side
    int stall_left = 0;
    always @(posedge i_clk) begin
        tvfl_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_fields.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out_data);
                n_fail++;
            end else begin
                want = expected_fields.pop_front();
                if (o_out_data.field_x !== want.field_x) begin
                    $display("%0t: field_x exp %h got %h", $time, want.field_x,
                             o_out_data.field_x);
                    n_fail++;
                end
                if (o_out_data.field_y !== want.field_y) begin
                    $display("%0t: field_y exp %h got %h", $time, want.field_y,
                             o_out_data.field_y);
                    n_fail++;
                end
                if (o_out_data.field_z !== want.field_z) begin
                    $display("%0t: field_z exp %h got %h", $time, want.field_z,
                             o_out_data.field_z);
                    n_fail++;
                end
                if (o_out_data.inside_res !== want.inside_res) begin
                    $display("%0t: inside_res exp %b got %b", $time, want.inside_res,
                             o_out_data.inside_res);
                    n_fail++;
                end
            end
        end
        if (rx_no_stall) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 9) < 3)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                         : $urandom_range(1, 3);
        end
    end

    logic [31:0] cfg_vals [7];

    initial begin
        tvfl_pkg::t_out zero_out;
        zero_out = '0;
        sh_origin = '{0, 0, 0};
        sh_inv_step = '{65536, 65536, 65536};
        sh_scale = 65536;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // load every entry that a query may touch
        tx_no_gap = 1'b1;
        for (int x = 0; x < GX; x++)
            for (int y = 0; y < GY; y++)
                for (int z = 0; z < GZ; z++)
                    if (is_loaded_idx(x, GX) && is_loaded_idx(y, GY) && is_loaded_idx(z, GZ))
                        send_item(mk(tvfl_pkg::FUNC_LOAD, $urandom, $urandom, $urandom,
                                     (x * GY + y) * GZ + z, $urandom, $urandom, $urandom),
                                  1'b0, zero_out);
        tx_no_gap = 1'b0;

        // outside the grid: zeros, inside flag clear
        add_row(mk(tvfl_pkg::FUNC_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0), 1);
        add_row(mk(tvfl_pkg::FUNC_QUERY, 0, 32'h8000_0000, 0, 0, 0, 0, 0), 1);
        add_row(mk(tvfl_pkg::FUNC_QUERY, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0), 1);
        add_row(mk(tvfl_pkg::FUNC_QUERY, (31 << 16) + 1, 0, 0, 0, 0, 0, 0), 1);
        add_row(mk(tvfl_pkg::FUNC_LOAD, 0, 0, 0, 0,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0);
        add_row(mk(tvfl_pkg::FUNC_LOAD, 0, 0, 0, CELLS - 1,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0);
        add_row(mk(tvfl_pkg::FUNC_LOAD, 0, 0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0), 0);
        add_row(mk(tvfl_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0), 0);
        add_row(mk(tvfl_pkg::FUNC_QUERY, 0, 0, 32'h0000_FFFF, 0, 0, 0, 0), 0);
        add_row(mk(tvfl_pkg::FUNC_QUERY, 0, 0, 32'h0000_8000, 0, 0, 0, 0), 0);
        // upper face on every axis: last cell, fraction one
        add_row(mk(tvfl_pkg::FUNC_QUERY, 31 << 16, 31 << 16, 31 << 16, 0, 0, 0, 0), 0);
        add_row(mk(tvfl_pkg::FUNC_QUERY, 31 << 16, 2 << 16, 0, 0, 0, 0, 0), 0);
        add_row(mk(tvfl_pkg::FUNC_QUERY, (31 << 16) - 1, (31 << 16) - 1, (31 << 16) - 1,
                   0, 0, 0, 0), 0);
        add_row(mk(tvfl_pkg::FUNC_QUERY, 32'h0002_1234, 32'h0001_ABCD, 32'h001E_FFFF,
                   0, 0, 0, 0), 0);
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        wait_idle();
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: cfg_vals = '{0, 0, 0, 65536, 65536, 65536, 65536};
                1: cfg_vals = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                1, 1, 1, 65536};
                2: cfg_vals = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
                3: cfg_vals = '{0, 0, 0, 0, 0, 0, 32'h8000_0000};
                4: cfg_vals = '{32'hFFFF_0000, 0, 32'h0001_0000, 65536, 32768, 131072, 0};
                default: begin
                    for (int a = 0; a < 3; a++) begin
                        cfg_vals[a] = $urandom_range(0, 1 << 21) - (1 << 20);
                        cfg_vals[tvfl_pkg::CFG_INV_STEP_X + a] = $urandom_range(4096, 1 << 20);
                    end
                    cfg_vals[tvfl_pkg::CFG_SCALE] = ($urandom_range(0, 3) == 0)
                                                    ? 32'h7FFF_FFFF : $urandom;
                end
            endcase
            write_regs(cfg_vals);
            rx_no_stall = (ph == 2);
            tx_no_gap = (ph == 3);
            for (int n = 0; n < 32; n++) begin
                if (ph == 0 && n == 16) wait_idle();
                send_item(random_item(), 1'b0, zero_out);
            end
            wait_idle();
        end

        if (n_fail == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
